// File: design/flhp_pkg.sv
// ----------------------------------------------------------------------------
// flhp_pkg: shared types and constants
// Frame record layout, result kinds and header-parsing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package flhp_pkg;

  localparam logic [7:0] MAX_FRAME          = 8'd255;
  localparam logic [2:0] MTYPE_JOIN_REQUEST = 3'b000;
  localparam logic [7:0] JOIN_MIN_LEN       = 8'd23;
  localparam logic [7:0] DATA_MIN_LEN       = 8'd12;
  localparam logic [7:0] MIC_LEN            = 8'd4;
  localparam logic [4:0] FHDR_MIN           = 5'd8;
  localparam int         QUEUE_DEPTH        = 2;

  typedef enum logic [1:0] {
    KIND_JOIN       = 2'd0,
    KIND_DATA       = 2'd1,
    KIND_SHORT_JOIN = 2'd2,
    KIND_SHORT_DATA = 2'd3
  } frame_kind_t;

  // One finished frame, as captured by the front end
  typedef struct packed {
    logic [2:0]  mtype;
    logic [7:0]  len;
    logic [3:0]  fopts_len;
    logic [63:0] addr_or_app_eui;
    logic [63:0] dev_eui;
    logic [15:0] counter;
    logic [15:0] nonce;
  } frame_rec_t;

endpackage

`default_nettype wire

// File: design/flhp_in_if.sv
// ----------------------------------------------------------------------------
// flhp_in_if: received byte channel
// One frame byte per item, with an end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface flhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: design/flhp_out_if.sv
// ----------------------------------------------------------------------------
// flhp_out_if: parsed header channel
// One item per frame with the decoded header fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface flhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_kind;
  logic [2:0]  message_type;
  logic [7:0]  frame_length;
  logic [31:0] device_address;
  logic [15:0] frame_counter;
  logic        port_present;
  logic [7:0]  payload_offset;
  logic [7:0]  payload_length;
  logic [63:0] app_eui;
  logic [63:0] dev_eui;
  logic [15:0] join_nonce;

  modport source (
    output valid, output frame_kind, output message_type, output frame_length,
    output device_address, output frame_counter, output port_present,
    output payload_offset, output payload_length, output app_eui,
    output dev_eui, output join_nonce, input ready
  );
  modport sink (
    input valid, input frame_kind, input message_type, input frame_length,
    input device_address, input frame_counter, input port_present,
    input payload_offset, input payload_length, input app_eui,
    input dev_eui, input join_nonce, output ready
  );
endinterface

`default_nettype wire

// File: design/lorawan_frame_header_parser_core.sv
// ----------------------------------------------------------------------------
// lorawan_frame_header_parser_core: LoRaWAN MAC header parser
// Parses a received frame byte by byte and reports one header item per frame.
// ----------------------------------------------------------------------------
//
//   channel | dir | item                         | accepted when
//   --------+-----+------------------------------+--------------------------
//   rx      | in  | rx_byte, frame_end           | rx.valid && rx.ready
//   res     | out | decoded header, one a frame  | res.valid && res.ready
//
// One byte per cycle is taken while the record queue has room; the byte
// counter and header capture registers in the front end are the only per-byte
// loop. A frame's result passes through the record queue and then the output
// register of the back end. Reset (rst, synchronous) empties the queue and
// starts a new frame. rx.ready drops only while the record queue is full,
// which takes res stalled with a result waiting and QueueDepth frames queued.
// ----------------------------------------------------------------------------
`default_nettype none

module lorawan_frame_header_parser_core #(
  parameter int QueueDepth = flhp_pkg::QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  flhp_in_if.sink    rx,
  flhp_out_if.source res
);
  import flhp_pkg::*;

  // front end -> queue
  logic       fr_valid, fr_ready;
  frame_rec_t fr_rec;
  // queue -> back end
  logic       bk_valid, bk_ready;
  frame_rec_t bk_rec;

  // Byte position tracking and header capture; a marked byte pushes a record
  flhp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .rec_valid (fr_valid),
    .rec_ready (fr_ready),
    .rec       (fr_rec)
  );

  // Decouples byte intake from result delivery
  flhp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_rec   (fr_rec),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_rec    (bk_rec)
  );

  // Frame classification, FOpts/payload arithmetic, output register
  flhp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (bk_valid),
    .rec_ready (bk_ready),
    .rec       (bk_rec),
    .res       (res)
  );

endmodule

`default_nettype wire

// File: design/flhp_front.sv
// ----------------------------------------------------------------------------
// flhp_front: byte capture
// Tracks byte position, captures header bytes and emits a frame record.
// ----------------------------------------------------------------------------
`default_nettype none

module flhp_front (
  input  wire                 clk,
  input  wire                 rst,
  flhp_in_if.sink             rx,
  output logic                rec_valid,
  input  wire                 rec_ready,
  output flhp_pkg::frame_rec_t rec
);
  import flhp_pkg::*;

  logic [7:0]  pos,     pos_next;
  logic [2:0]  mtype,   mtype_next;
  logic [3:0]  fopts,   fopts_next;
  logic [63:0] addr,    addr_next;
  logic [63:0] deveui,  deveui_next;
  logic [15:0] cnt,     cnt_next;
  logic [15:0] nonce,   nonce_next;
  logic        accept;

  assign rx.ready  = rec_ready;
  assign accept    = rx.valid && rec_ready;
  assign rec_valid = rx.valid && rx.frame_end;

  always_comb begin
    pos_next    = pos;
    mtype_next  = mtype;
    fopts_next  = fopts;
    addr_next   = addr;
    deveui_next = deveui;
    cnt_next    = cnt;
    nonce_next  = nonce;
    if (pos < MAX_FRAME) begin
      pos_next = pos + 8'd1;
      if (pos == 8'd0) mtype_next = rx.rx_byte[7:5];
      if (pos == 8'd5) fopts_next = rx.rx_byte[3:0];
      for (int i = 0; i < 8; i++) begin
        if (pos == 8'(i + 1)) addr_next[8*i +: 8] = rx.rx_byte;
        if (pos == 8'(i + 9)) deveui_next[8*i +: 8] = rx.rx_byte;
      end
      for (int i = 0; i < 2; i++) begin
        if (pos == 8'(i + 6))  cnt_next[8*i +: 8] = rx.rx_byte;
        if (pos == 8'(i + 17)) nonce_next[8*i +: 8] = rx.rx_byte;
      end
    end
  end

  always_comb begin
    rec.mtype           = mtype_next;
    rec.len             = pos_next;
    rec.fopts_len       = fopts_next;
    rec.addr_or_app_eui = addr_next;
    rec.dev_eui         = deveui_next;
    rec.counter         = cnt_next;
    rec.nonce           = nonce_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && rx.frame_end)) begin
      pos    <= '0;
      mtype  <= '0;
      fopts  <= '0;
      addr   <= '0;
      deveui <= '0;
      cnt    <= '0;
      nonce  <= '0;
    end else if (accept) begin
      pos    <= pos_next;
      mtype  <= mtype_next;
      fopts  <= fopts_next;
      addr   <= addr_next;
      deveui <= deveui_next;
      cnt    <= cnt_next;
      nonce  <= nonce_next;
    end
  end

endmodule

`default_nettype wire

// File: design/flhp_queue.sv
// ----------------------------------------------------------------------------
// flhp_queue: frame record queue
// Small FIFO of finished frame records between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module flhp_queue #(
  parameter int Depth = flhp_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  flhp_pkg::frame_rec_t push_rec,
  output logic                 pop_valid,
  input  wire                  pop_ready,
  output flhp_pkg::frame_rec_t pop_rec
);
  import flhp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  frame_rec_t      slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push, pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_rec    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      if (push && !pop)      count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

endmodule

`default_nettype wire

// File: design/flhp_back.sv
// ----------------------------------------------------------------------------
// flhp_back: header decode
// Classifies a frame record and registers the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module flhp_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  rec_valid,
  output logic                 rec_ready,
  input  flhp_pkg::frame_rec_t rec,
  flhp_out_if.source           res
);
  import flhp_pkg::*;

  logic        valid;
  frame_kind_t kind, kind_next;
  logic [2:0]  mtype;
  logic [7:0]  len;
  logic [31:0] node_addr, node_addr_next;
  logic [15:0] fcnt, fcnt_next;
  logic        port, port_next;
  logic [7:0]  poff, poff_next;
  logic [7:0]  plen, plen_next;
  logic [63:0] appeui, appeui_next;
  logic [63:0] deveui, deveui_next;
  logic [15:0] nonce, nonce_next;
  logic [7:0]  fhdr_end, mic_start;
  logic        load;

  assign rec_ready = !valid || res.ready;
  assign load      = rec_valid && rec_ready;

  assign fhdr_end  = {3'b000, FHDR_MIN + {1'b0, rec.fopts_len}};
  assign mic_start = rec.len - MIC_LEN;

  always_comb begin
    kind_next      = KIND_SHORT_DATA;
    node_addr_next = '0;
    fcnt_next      = '0;
    port_next      = 1'b0;
    poff_next      = '0;
    plen_next      = '0;
    appeui_next    = '0;
    deveui_next    = '0;
    nonce_next     = '0;
    if (rec.mtype == MTYPE_JOIN_REQUEST) begin
      if (rec.len < JOIN_MIN_LEN) begin
        kind_next = KIND_SHORT_JOIN;
      end else begin
        kind_next   = KIND_JOIN;
        appeui_next = rec.addr_or_app_eui;
        deveui_next = rec.dev_eui;
        nonce_next  = rec.nonce;
      end
    end else if (rec.len >= DATA_MIN_LEN) begin
      kind_next      = KIND_DATA;
      node_addr_next = rec.addr_or_app_eui[31:0];
      fcnt_next      = rec.counter;
      if (fhdr_end < mic_start) begin
        port_next = 1'b1;
        poff_next = fhdr_end + 8'd1;
        plen_next = mic_start - (fhdr_end + 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rec_ready) begin
      valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind      <= kind_next;
      mtype     <= rec.mtype;
      len       <= rec.len;
      node_addr <= node_addr_next;
      fcnt      <= fcnt_next;
      port      <= port_next;
      poff      <= poff_next;
      plen      <= plen_next;
      appeui    <= appeui_next;
      deveui    <= deveui_next;
      nonce     <= nonce_next;
    end
  end

  assign res.valid          = valid;
  assign res.frame_kind     = kind;
  assign res.message_type   = mtype;
  assign res.frame_length   = len;
  assign res.device_address = node_addr;
  assign res.frame_counter  = fcnt;
  assign res.port_present   = port;
  assign res.payload_offset = poff;
  assign res.payload_length = plen;
  assign res.app_eui        = appeui;
  assign res.dev_eui        = deveui;
  assign res.join_nonce     = nonce;

endmodule

`default_nettype wire

// File: tb/lorawan_frame_header_parser_core_tb.sv
// ----------------------------------------------------------------------------
// lorawan_frame_header_parser_core_tb: self-checking bench for the header parser
// Streams whole frames byte by byte into the rx channel and checks each result
// item against a cycle-free predictor of the capture and decode rules. Runs
// four traffic phases: no idling, sender gaps, receiver stalls, and both.
// ----------------------------------------------------------------------------
module lorawan_frame_header_parser_core_tb;
  import flhp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;     // wait after the last phase before the final check
  localparam int TOTAL_BYTES    = 1400;   // byte budget over all phases
  localparam int PHASE_FRAMES   = 4;
  localparam int NUM_PHASES     = 4;

  // Per-phase idle rates, percent of cycles
  localparam int SEND_IDLE  [NUM_PHASES] = '{0, 63, 0, 26};
  localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 63, 26};

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [2:0]  mtype;
    logic [7:0]  len;
    logic [31:0] node_addr;
    logic [15:0] fcnt;
    logic        port;
    logic [7:0]  pay_off;
    logic [7:0]  pay_len;
    logic [63:0] app_eui;
    logic [63:0] dev_eui;
    logic [15:0] nonce;
  } header_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  flhp_in_if  rx_ch ();
  flhp_out_if res_ch ();

  lorawan_frame_header_parser_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  frame_byte_t pending_bytes[$];
  header_t     expected_headers[$];
  frame_byte_t drive_item;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          error_count    = 0;
  int          quiet_cycles   = 0;

  // Predictor copy of the parser's frame state
  logic [7:0]  byte_count;
  logic [7:0]  mhdr;
  logic [7:0]  fctrl;
  logic [63:0] addr_app_eui;
  logic [63:0] dev_eui_acc;
  logic [15:0] fcnt_acc;
  logic [15:0] nonce_acc;

  task automatic clear_frame();
    byte_count   = '0;
    mhdr         = '0;
    fctrl        = '0;
    addr_app_eui = '0;
    dev_eui_acc  = '0;
    fcnt_acc     = '0;
    nonce_acc    = '0;
  endtask

  // Capture one accepted byte; on the end mark, decode and queue the header.
  task automatic parse_rx_byte(input logic [7:0] b, input logic last);
    int      pos;
    int      fhdr_end;
    int      mic_start;
    header_t h;
    pos = byte_count;
    // Bytes past the maximum length are dropped; the frame is cut there
    if (byte_count < MAX_FRAME) begin
      if (pos == 0) mhdr = b;
      if (pos >= 1 && pos <= 8) addr_app_eui[8*(pos-1) +: 8] = b;
      if (pos == 5) fctrl = b;
      if (pos == 6 || pos == 7) fcnt_acc[8*(pos-6) +: 8] = b;
      if (pos >= 9 && pos <= 16) dev_eui_acc[8*(pos-9) +: 8] = b;
      if (pos == 17 || pos == 18) nonce_acc[8*(pos-17) +: 8] = b;
      byte_count = byte_count + 8'd1;
    end
    if (last) begin
      h       = '0;
      h.mtype = mhdr[7:5];
      h.len   = byte_count;
      if (h.mtype == MTYPE_JOIN_REQUEST) begin
        if (byte_count < JOIN_MIN_LEN) begin
          h.kind = KIND_SHORT_JOIN;
        end else begin
          h.kind    = KIND_JOIN;
          h.app_eui = addr_app_eui;
          h.dev_eui = dev_eui_acc;
          h.nonce   = nonce_acc;
        end
      end else if (byte_count < DATA_MIN_LEN) begin
        h.kind = KIND_SHORT_DATA;
      end else begin
        h.kind      = KIND_DATA;
        h.node_addr = addr_app_eui[31:0];
        h.fcnt      = fcnt_acc;
        // FHDR runs through FOpts; the port byte follows if room before MIC
        fhdr_end  = int'(FHDR_MIN) + int'(fctrl[3:0]);
        mic_start = int'(byte_count) - int'(MIC_LEN);
        if (fhdr_end < mic_start) begin
          h.port    = 1'b1;
          h.pay_off = 8'(fhdr_end + 1);
          h.pay_len = 8'(mic_start - fhdr_end - 1);
        end
      end
      expected_headers.push_back(h);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_header();
    header_t want;
    if (expected_headers.size() == 0) begin
      $display("%0t: result item with no frame pending, kind %0d length %0d",
               $time, res_ch.frame_kind, res_ch.frame_length);
      error_count++;
    end else begin
      want = expected_headers.pop_front();
      check_field("frame_kind",     res_ch.frame_kind,     want.kind);
      check_field("message_type",   res_ch.message_type,   want.mtype);
      check_field("frame_length",   res_ch.frame_length,   want.len);
      check_field("device_address", res_ch.device_address, want.node_addr);
      check_field("frame_counter",  res_ch.frame_counter,  want.fcnt);
      check_field("port_present",   res_ch.port_present,   want.port);
      check_field("payload_offset", res_ch.payload_offset, want.pay_off);
      check_field("payload_length", res_ch.payload_length, want.pay_len);
      check_field("app_eui",        res_ch.app_eui,        want.app_eui);
      check_field("dev_eui",        res_ch.dev_eui,        want.dev_eui);
      check_field("join_nonce",     res_ch.join_nonce,     want.nonce);
    end
  endtask

  // Build one frame; byte 0 carries the type, byte 5 the FOpts length.
  task automatic queue_frame(input int len, input logic [2:0] mtype,
                             input logic [3:0] fopts, input fill_t fill);
    frame_byte_t fb;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: fb.data = 8'h00;
        FILL_ONES: fb.data = 8'hFF;
        default:   fb.data = 8'($urandom);
      endcase
      if (i == 0) fb.data[7:5] = mtype;
      if (i == 5) fb.data[3:0] = fopts;
      fb.last = (i == len - 1);
      pending_bytes.push_back(fb);
    end
  endtask

  task automatic queue_random_frame(output int len);
    logic [2:0] mtype;
    int         sel;
    fill_t      fill;
    // Join requests are sent often so the long join decode gets exercised
    mtype = ($urandom_range(99) < 40) ? 3'd0 : 3'($urandom_range(7, 1));
    sel   = $urandom_range(99);
    if (sel < 75)      len = (mtype == 3'd0) ? $urandom_range(34, 18) : $urandom_range(32, 8);
    else if (sel < 97) len = $urandom_range(120, 1);
    else               len = $urandom_range(270, 250);  // straddles saturation
    sel  = $urandom_range(99);
    fill = (sel < 3) ? FILL_ZERO : (sel < 6) ? FILL_ONES : FILL_RANDOM;
    queue_frame(len, mtype, 4'($urandom_range(15)), fill);
  endtask

  // Directed frames: length and FOpts boundaries, every type, saturation.
  task automatic queue_directed();
    queue_frame(1,   3'd0, 4'd0,  FILL_RANDOM);  // lone byte, short join
    queue_frame(1,   3'd2, 4'd0,  FILL_RANDOM);  // lone byte, short data
    queue_frame(22,  3'd0, 4'd0,  FILL_RANDOM);  // one short of full join
    queue_frame(23,  3'd0, 4'd0,  FILL_RANDOM);  // smallest full join
    queue_frame(23,  3'd0, 4'd15, FILL_ONES);
    queue_frame(23,  3'd0, 4'd0,  FILL_ZERO);
    queue_frame(11,  3'd2, 4'd0,  FILL_RANDOM);  // one short of data header
    queue_frame(12,  3'd2, 4'd0,  FILL_RANDOM);  // header and MIC, no port
    queue_frame(13,  3'd4, 4'd0,  FILL_RANDOM);  // port byte, empty payload
    queue_frame(13,  3'd4, 4'd1,  FILL_RANDOM);  // FOpts eat the port byte
    queue_frame(27,  3'd3, 4'd15, FILL_RANDOM);  // max FOpts, no room for port
    queue_frame(28,  3'd3, 4'd15, FILL_RANDOM);  // max FOpts, port just fits
    for (int t = 1; t < 8; t++) queue_frame(20, 3'(t), 4'(t), FILL_RANDOM);
    queue_frame(40,  3'd7, 4'd15, FILL_ONES);
    queue_frame(40,  3'd1, 4'd0,  FILL_ZERO);
    queue_frame(256, 3'd0, 4'd0,  FILL_RANDOM);  // one byte past the maximum
  endtask

  // Driver: load a new byte, unless an idle cycle is drawn, whenever the slot is empty or just taken.
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_ch.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = pending_bytes.pop_front();
        rx_ch.valid     <= 1'b1;
        rx_ch.rx_byte   <= drive_item.data;
        rx_ch.frame_end <= drive_item.last;
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results before predicting, both on pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) check_header();
      if (rx_ch.valid && rx_ch.ready) parse_rx_byte(rx_ch.rx_byte, rx_ch.frame_end);
    end
  end

  // Watchdog: a long run of cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("lorawan_frame_header_parser_core test failed");
      $finish;
    end
  end

  initial begin
    int n;
    int phase_bytes;
    int phase_frames;
    int phase_target;
    int sent_bytes;
    rx_ch.valid     = 1'b0;
    rx_ch.rx_byte   = 8'h00;
    rx_ch.frame_end = 1'b0;
    res_ch.ready    = 1'b0;
    sent_bytes      = 0;
    clear_frame();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      if (ph == 0) queue_directed();
      // Directed bytes count toward the first phase; later phases share the rest
      phase_target = (TOTAL_BYTES - sent_bytes) / (NUM_PHASES - ph);
      phase_bytes  = pending_bytes.size();
      phase_frames = 0;
      while (phase_bytes < phase_target || phase_frames < PHASE_FRAMES) begin
        queue_random_frame(n);
        phase_bytes += n;
        phase_frames++;
      end
      sent_bytes += phase_bytes;
      // Phase ends once every byte is taken and every header has come back
      while (pending_bytes.size() != 0 || rx_ch.valid || expected_headers.size() != 0)
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_headers.size() != 0) begin
      $display("%0t: %0d headers never arrived", $time, expected_headers.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("lorawan_frame_header_parser_core test passed");
    end else begin
      $display("lorawan_frame_header_parser_core test failed");
    end
    $finish;
  end

endmodule
